/* hdl/gsgr_pkg.sv */
// gsgr_pkg: shared types and codes for the graph scatter/gather round block.
// No dependencies.
`timescale 1ns / 1ps
package gsgr_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_REQ,
    ST_RD_OUT,
    ST_MRG_INIT,
    ST_MRG_FETCH,
    ST_MRG_CMP,
    ST_MRG_PASS,
    ST_SCAN_FETCH,
    ST_SCAN_WR,
    ST_RUN_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;       // drop all entries
    logic load;        // append capture-register entry
    logic rd_req;      // issue read of read index
    logic rd_out;      // present read result
    logic run_out;     // present run result
    logic mrg_init;    // start sort pass sequence
    logic mrg_fetch;   // fetch heads of the two runs
    logic mrg_take;    // move one entry to the other bank
    logic mrg_pass;    // end of one pass: double width, swap banks
    logic by_dst;      // sort key select
    logic scan_init;   // restart scan
    logic scan_fetch;  // read one entry for scan
    logic scan_wr;     // write back scanned entry
    logic gather;      // 0 scatter scan, 1 gather scan
  } gsgr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;
    logic run_done;    // merge: every run of this pass handled
    logic width_done;  // sort complete
    logic scan_done;   // scan reached the end
  } gsgr_sts_t;

endpackage

/* hdl/gsgr_ctrl.sv */
// gsgr_ctrl: sequencing state machine for clear, load, read and the two-sort round.
// Depends on gsgr_pkg.
`timescale 1ns / 1ps
module gsgr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_action,
  output logic                busy,
  output gsgr_pkg::gsgr_cmd_t cmd,
  input  gsgr_pkg::gsgr_sts_t sts
);

  gsgr_pkg::state_t state_r, state_nxt;
  logic             phase_r, phase_nxt;  // 0 source sort/scatter, 1 destination/gather

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsgr_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.by_dst = phase_r;
    cmd.gather = phase_r;
    busy      = (state_r != gsgr_pkg::ST_IDLE);
    unique case (state_r)
      gsgr_pkg::ST_IDLE: begin
        if (start) begin
          unique case (gsgr_pkg::action_t'(in_action))
            gsgr_pkg::ACT_CLEAR: cmd.clear = 1'b1;
            gsgr_pkg::ACT_LOAD:  state_nxt = gsgr_pkg::ST_LOAD;
            gsgr_pkg::ACT_READ:  state_nxt = gsgr_pkg::ST_RD_REQ;
            gsgr_pkg::ACT_RUN: begin
              phase_nxt = 1'b0;
              state_nxt = sts.empty ? gsgr_pkg::ST_RUN_DONE : gsgr_pkg::ST_MRG_INIT;
            end
            default: state_nxt = gsgr_pkg::ST_IDLE;
          endcase
        end
      end
      gsgr_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = gsgr_pkg::ST_IDLE;
      end
      gsgr_pkg::ST_RD_REQ: begin
        cmd.rd_req = 1'b1;
        state_nxt  = gsgr_pkg::ST_RD_OUT;
      end
      gsgr_pkg::ST_RD_OUT: begin
        cmd.rd_out = 1'b1;
        state_nxt  = gsgr_pkg::ST_IDLE;
      end
      gsgr_pkg::ST_MRG_INIT: begin
        cmd.mrg_init = 1'b1;
        state_nxt    = gsgr_pkg::ST_MRG_FETCH;
      end
      gsgr_pkg::ST_MRG_FETCH: begin
        priority if (sts.width_done) begin
          cmd.scan_init = 1'b1;
          state_nxt     = gsgr_pkg::ST_SCAN_FETCH;
        end else if (sts.run_done) begin
          state_nxt = gsgr_pkg::ST_MRG_PASS;
        end else begin
          cmd.mrg_fetch = 1'b1;
          state_nxt     = gsgr_pkg::ST_MRG_CMP;
        end
      end
      gsgr_pkg::ST_MRG_CMP: begin
        cmd.mrg_take = 1'b1;
        state_nxt    = gsgr_pkg::ST_MRG_FETCH;
      end
      gsgr_pkg::ST_MRG_PASS: begin
        cmd.mrg_pass = 1'b1;
        state_nxt    = gsgr_pkg::ST_MRG_FETCH;
      end
      gsgr_pkg::ST_SCAN_FETCH: begin
        if (sts.scan_done) begin
          if (phase_r) begin
            state_nxt = gsgr_pkg::ST_RUN_DONE;
          end else begin
            phase_nxt = 1'b1;
            state_nxt = gsgr_pkg::ST_MRG_INIT;
          end
        end else begin
          cmd.scan_fetch = 1'b1;
          state_nxt      = gsgr_pkg::ST_SCAN_WR;
        end
      end
      gsgr_pkg::ST_SCAN_WR: begin
        cmd.scan_wr = 1'b1;
        state_nxt   = gsgr_pkg::ST_SCAN_FETCH;
      end
      gsgr_pkg::ST_RUN_DONE: begin
        cmd.run_out = 1'b1;
        state_nxt   = gsgr_pkg::ST_IDLE;
      end
      default: state_nxt = gsgr_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/gsgr_dp.sv */
// gsgr_dp: two-bank entry store, merge-sort datapath, scan accumulator, result regs.
// Depends on gsgr_pkg.
`timescale 1ns / 1ps
module gsgr_dp #(
  parameter int MAX_ENTRIES = 1024,
  parameter int ID_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cap_en,
  input  logic [15:0]         in_src_vertex,
  input  logic [15:0]         in_dst_vertex,
  input  logic                in_is_vertex,
  input  logic signed [31:0]  in_value_in,
  input  logic [9:0]          in_read_index,
  input  gsgr_pkg::gsgr_cmd_t cmd,
  output gsgr_pkg::gsgr_sts_t sts,
  output logic                out_valid,
  output logic [15:0]         out_src_out,
  output logic [15:0]         out_dst_out,
  output logic                out_is_vertex_out,
  output logic signed [31:0]  out_value_out,
  output logic [10:0]         out_entry_count,
  output logic                out_overflowed
);

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = AW + 1;
  localparam int EW  = 2 * ID_BITS + 1 + 32;
  localparam int IDW = (ID_BITS < 16) ? ID_BITS : 16;

  typedef struct packed {
    logic [ID_BITS-1:0] src;
    logic [ID_BITS-1:0] dst;
    logic               isv;
    logic [31:0]        val;
  } ent_t;

  // Two banks, ping-pong between merge passes.
  logic [EW-1:0] bank0 [MAX_ENTRIES];
  logic [EW-1:0] bank1 [MAX_ENTRIES];

  logic          sel_r;              // bank holding current order
  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  ent_t          cap_r;
  logic [9:0]    ridx_r;

  // merge state
  logic [CW:0]   width_r, lo_r, a_r, b_r, o_r;
  logic [CW:0]   mid_w, hi_w;

  // scan state
  logic [CW-1:0] si_r;
  logic [31:0]   acc_r;

  // read ports (registered)
  logic [AW-1:0] ra_addr, rb_addr;
  logic [EW-1:0] ra0_r, ra1_r, rb0_r, rb1_r;
  ent_t          ra_q, rb_q;

  // write port
  logic          we;
  logic          we_bank;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  logic [CW:0]   n_ext;
  logic          a_ok, b_ok, take_a;
  logic [ID_BITS:0] ka, kb;

  assign n_ext = {1'b0, cnt_r};
  always_comb begin
    mid_w = ((lo_r + width_r) < n_ext) ? lo_r + width_r : n_ext;
    hi_w  = ((mid_w + width_r) < n_ext) ? mid_w + width_r : n_ext;
  end

  assign ra_q = ent_t'(sel_r ? ra1_r : ra0_r);
  assign rb_q = ent_t'(sel_r ? rb1_r : rb0_r);

  // Read addresses: merge heads or scan index or host read.
  always_comb begin
    ra_addr = a_r[AW-1:0];
    rb_addr = b_r[AW-1:0];
    if (cmd.scan_fetch) ra_addr = si_r[AW-1:0];
    if (cmd.rd_req)     ra_addr = ridx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    ra0_r <= bank0[ra_addr];
    ra1_r <= bank1[ra_addr];
    rb0_r <= bank0[rb_addr];
    rb1_r <= bank1[rb_addr];
    if (we) begin
      if (we_bank) bank1[wa] <= wd;
      else         bank0[wa] <= wd;
    end
  end

  // run heads come straight from the registered reads issued in the fetch cycle
  always_comb begin
    ka = cmd.by_dst ? {ra_q.dst, ra_q.isv} : {ra_q.src, ~ra_q.isv};
    kb = cmd.by_dst ? {rb_q.dst, rb_q.isv} : {rb_q.src, ~rb_q.isv};
    a_ok = a_r < mid_w;
    b_ok = b_r < hi_w;
    priority if (!a_ok)     take_a = 1'b0;
    else if (!b_ok)         take_a = 1'b1;
    else                    take_a = (ka <= kb);
  end

  ent_t scan_ent;
  always_comb begin
    scan_ent = ra_q;
    if (cmd.gather) begin
      if (ra_q.isv) scan_ent.val = acc_r;
    end else if (!ra_q.isv) begin
      scan_ent.val = acc_r;
    end
  end

  always_comb begin
    we = 1'b0; we_bank = sel_r; wa = '0; wd = '0;
    if (cmd.load) begin
      // a load into a full list is dropped
      we = (cnt_r < CW'(MAX_ENTRIES)); wa = cnt_r[AW-1:0]; wd = cap_r;
    end else if (cmd.mrg_take) begin
      we = 1'b1; we_bank = ~sel_r; wa = o_r[AW-1:0];
      wd = take_a ? ra_q : rb_q;
    end else if (cmd.scan_wr) begin
      we = 1'b1; wa = si_r[AW-1:0]; wd = scan_ent;
    end
  end

  // status flags, combinational from the count and the merge and scan pointers
  assign sts.empty      = (cnt_r == '0);
  assign sts.run_done   = (lo_r >= n_ext);
  assign sts.width_done = (width_r >= n_ext);
  assign sts.scan_done  = (si_r == cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      sel_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.rd_out | cmd.run_out;
      if (cmd.clear) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.load) begin
        if (cnt_r < CW'(MAX_ENTRIES)) cnt_r <= cnt_r + 1'b1;
        else                          ovf_r <= 1'b1;
      end
      if (cmd.mrg_pass) sel_r <= ~sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      cap_r.src <= ID_BITS'({16'd0, in_src_vertex});
      cap_r.dst <= ID_BITS'({16'd0, in_dst_vertex});
      cap_r.isv <= in_is_vertex;
      cap_r.val <= in_value_in;
      ridx_r    <= in_read_index;
    end
    if (cmd.mrg_init) begin
      width_r <= (CW+1)'(1);
      lo_r    <= '0;
      a_r     <= '0;
      b_r     <= (CW+1)'(1);
      o_r     <= '0;
    end
    if (cmd.mrg_take) begin
      o_r <= o_r + 1'b1;
      if (take_a) a_r <= a_r + 1'b1;
      else        b_r <= b_r + 1'b1;
      if (o_r + 1'b1 >= hi_w) begin
        lo_r <= hi_w;
        a_r  <= hi_w;
        b_r  <= ((hi_w + width_r) < n_ext) ? hi_w + width_r : n_ext;
      end
    end
    if (cmd.mrg_pass) begin
      width_r <= width_r << 1;
      lo_r    <= '0;
      a_r     <= '0;
      b_r     <= ((width_r << 1) < n_ext) ? (width_r << 1) : n_ext;
      o_r     <= '0;
    end
    if (cmd.scan_init) begin
      si_r  <= '0;
      acc_r <= '0;
    end
    if (cmd.scan_wr) begin
      si_r <= si_r + 1'b1;
      if (cmd.gather) acc_r <= ra_q.isv ? 32'd0 : acc_r + ra_q.val;
      else if (ra_q.isv) acc_r <= ra_q.val;
    end
    if (cmd.rd_out | cmd.run_out) begin
      out_src_out       <= '0;
      out_dst_out       <= '0;
      out_is_vertex_out <= 1'b0;
      out_value_out     <= '0;
      if (cmd.rd_out && ({1'b0, ridx_r} < 11'(cnt_r))) begin
        out_src_out       <= 16'(ra_q.src[IDW-1:0]);
        out_dst_out       <= 16'(ra_q.dst[IDW-1:0]);
        out_is_vertex_out <= ra_q.isv;
        out_value_out     <= ra_q.val;
      end
      out_entry_count <= 11'(cnt_r);
      out_overflowed  <= ovf_r;
    end
  end

endmodule

/* hdl/graph_scatter_gather_round_top.sv */
// Graph scatter/gather round: clear, load and read; run is two bottom-up merge
// sorts (each entry moved by a fetch step and a take step through one bank write
// port) plus two scans.
// Result strobe comes the cycle after the operation finishes; busy blocks start.
// rst_n synchronous: count and overflow cleared, store contents undefined.
`timescale 1ns / 1ps
module graph_scatter_gather_round_top #(
  parameter int MAX_ENTRIES = 1024,
  parameter int ID_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_src_vertex,
  input  logic [15:0]        in_dst_vertex,
  input  logic               in_is_vertex,
  input  logic signed [31:0] in_value_in,
  input  logic [9:0]         in_read_index,
  output logic               out_valid,
  output logic [15:0]        out_src_out,
  output logic [15:0]        out_dst_out,
  output logic               out_is_vertex_out,
  output logic signed [31:0] out_value_out,
  output logic [10:0]        out_entry_count,
  output logic               out_overflowed
);

  gsgr_pkg::gsgr_cmd_t cmd;
  gsgr_pkg::gsgr_sts_t sts;

  gsgr_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_action, .busy, .cmd, .sts
  );

  gsgr_dp #(.MAX_ENTRIES(MAX_ENTRIES), .ID_BITS(ID_BITS)) u_dp (
    .clk, .rst_n,
    .cap_en(start & ~busy),
    .in_src_vertex, .in_dst_vertex, .in_is_vertex, .in_value_in, .in_read_index,
    .cmd, .sts,
    .out_valid, .out_src_out, .out_dst_out, .out_is_vertex_out,
    .out_value_out, .out_entry_count, .out_overflowed
  );

endmodule

/* hdl/gsgr_chk.sv */
// gsgr_chk: port-level checks for the scatter/gather round block.
// Depends on graph_scatter_gather_round_top (bound to it) and gsgr_pkg.
`timescale 1ns / 1ps
module gsgr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic [10:0] out_entry_count
);

  a_no_strobe_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == gsgr_pkg::ACT_CLEAR) |=> !out_valid)
    else $error("strobe on clear");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("active after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 11'd1024) else $error("count too big");

  a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_valid) else $error("spurious strobe");

endmodule

bind graph_scatter_gather_round_top gsgr_chk u_chk (
  .clk, .rst_n, .start, .busy, .in_action, .out_valid, .out_entry_count
);
